// ===== src/gn3_pkg.sv =====
// Package for the 3D gradient noise pipeline: widths, permutation ROM
// and gradient select.
// No dependencies.
package gn3_pkg;

    localparam int FRAC_BITS = 16;
    localparam int COORD_W   = 32;
    localparam int NOISE_W   = 18;
    // fraction, fade weight (0..one), signed offsets and values
    localparam int FR_W  = FRAC_BITS;
    localparam int WT_W  = FRAC_BITS + 1;
    localparam int OFF_W = FRAC_BITS + 1;
    localparam int VAL_W = FRAC_BITS + 4;

    typedef logic [FR_W-1:0]          frac_t;
    typedef logic [WT_W-1:0]          weight_t;
    typedef logic signed [OFF_W-1:0]  off_t;
    typedef logic signed [VAL_W-1:0]  val_t;

    localparam logic [7:0] PERM_ROM [256] = '{
        8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,
        8'd194,8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
        8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,
        8'd0,8'd26,8'd197,8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
        8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,
        8'd171,8'd168,8'd68,8'd175,8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
        8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,
        8'd220,8'd105,8'd92,8'd41,8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
        8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,
        8'd208,8'd89,8'd18,8'd169,8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,
        8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,8'd52,8'd217,8'd226,8'd250,
        8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,
        8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,8'd182,8'd189,8'd28,8'd42,
        8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,
        8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,8'd129,8'd22,8'd39,8'd253,
        8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,
        8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,8'd238,8'd210,8'd144,8'd12,
        8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
        8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,8'd184,8'd84,8'd204,8'd176,
        8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
        8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,8'd128,8'd195,8'd78,8'd66,
        8'd215,8'd61,8'd156,8'd180
    };

    // gradient codes with special v selection
    localparam logic [3:0] GRAD_VX_A = 4'd12;
    localparam logic [3:0] GRAD_VX_B = 4'd14;

    // Dot of one of 16 gradients with a corner offset
    function automatic val_t grad(input logic [3:0] h, input off_t x, input off_t y,
                                  input off_t z);
        off_t u;
        off_t v;
        val_t su;
        val_t sv;
        u = (h < 4'd8) ? x : y;
        v = (h < 4'd4) ? y : ((h == GRAD_VX_A || h == GRAD_VX_B) ? x : z);
        su = h[0] ? -val_t'(u) : val_t'(u);
        sv = h[1] ? -val_t'(v) : val_t'(v);
        return su + sv;
    endfunction

endpackage

// ===== src/gn3_if.sv =====
// Valid/ready stream interface for the 3D gradient noise block.
// Depends on gn3_pkg.
interface gn3_in_if;
    logic valid;
    logic ready;
    logic signed [gn3_pkg::COORD_W-1:0] coord_x;
    logic signed [gn3_pkg::COORD_W-1:0] coord_y;
    logic signed [gn3_pkg::COORD_W-1:0] coord_z;
    modport source (output valid, coord_x, coord_y, coord_z, input ready);
    modport sink   (input valid, coord_x, coord_y, coord_z, output ready);
endinterface

interface gn3_out_if;
    logic valid;
    logic ready;
    logic signed [gn3_pkg::NOISE_W-1:0] noise_value;
    modport source (output valid, noise_value, input ready);
    modport sink   (input valid, noise_value, output ready);
endinterface

// ===== src/gradient_noise_3d_top.sv =====
// Throughput one per cycle while the output is not stalled.
// Stages: ROM hash chain (3) with the fade multiplies alongside, gradients and fade
// product, three lerp product stages, final sum, output saturation.
// The whole pipeline advances together; a stall holds every stage.
// Reset (rst_n, async, active low) clears all stage valid bits only.
// Top level of the 3D gradient noise pipeline; depends on gn3_pkg and gn3_if.
module gradient_noise_3d_top (
    input  logic        clk,
    input  logic        rst_n,
    gn3_in_if.sink      in_ch,
    gn3_out_if.source   out_ch
);
    localparam int NST = 9;
    localparam int F   = gn3_pkg::FRAC_BITS;
    localparam int PW  = F + 8;   // width of the fade polynomial term
    localparam logic [F:0] ONE = (F+1)'(1) << F;

    logic [NST-1:0] vld_reg;
    logic           adv;

    // advance whenever the last stage is empty or being taken
    assign adv = !vld_reg[NST-1] || out_ch.ready;
    assign in_ch.ready = adv;
    assign out_ch.valid = vld_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NST-2:0], in_ch.valid};
        end
    end

    // ---------------- stage 1: split, first ROM reads
    logic [7:0]          cy1_reg, cz1_reg;
    gn3_pkg::frac_t      fr1_reg [3];
    logic [7:0]          ra1_reg, rb1_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cy1_reg    <= in_ch.coord_y[F +: 8];
            cz1_reg    <= in_ch.coord_z[F +: 8];
            fr1_reg[0] <= in_ch.coord_x[F-1:0];
            fr1_reg[1] <= in_ch.coord_y[F-1:0];
            fr1_reg[2] <= in_ch.coord_z[F-1:0];
            ra1_reg    <= gn3_pkg::PERM_ROM[in_ch.coord_x[F +: 8]];
            rb1_reg    <= gn3_pkg::PERM_ROM[8'(in_ch.coord_x[F +: 8] + 8'd1)];
        end
    end

    // ---------------- stage 2: a, b and second ROM reads; t^2 products
    logic [7:0]     a_w, b_w;
    logic [7:0]     aa2_reg, ab2_reg, ba2_reg, bb2_reg;
    logic [7:0]     cz2_reg;
    gn3_pkg::frac_t fr2_reg [3];
    logic [2*F-1:0] tt2_reg [3];

    assign a_w = ra1_reg + cy1_reg;
    assign b_w = rb1_reg + cy1_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            aa2_reg <= gn3_pkg::PERM_ROM[a_w];
            ab2_reg <= gn3_pkg::PERM_ROM[8'(a_w + 8'd1)];
            ba2_reg <= gn3_pkg::PERM_ROM[b_w];
            bb2_reg <= gn3_pkg::PERM_ROM[8'(b_w + 8'd1)];
            cz2_reg <= cz1_reg;
            for (int k = 0; k < 3; k++)
            begin
                fr2_reg[k] <= fr1_reg[k];
                tt2_reg[k] <= fr1_reg[k] * fr1_reg[k];
            end
        end
    end

    // ---------------- stage 3: corner hashes; t3 product, poly
    logic [7:0]     aa_w, ab_w, ba_w, bb_w;
    logic [3:0]     h3_reg [8];
    gn3_pkg::frac_t fr3_reg [3];
    logic [2*F-1:0] t3p_reg [3];
    logic [PW-1:0]  p3_reg  [3];

    assign aa_w = aa2_reg + cz2_reg;
    assign ab_w = ab2_reg + cz2_reg;
    assign ba_w = ba2_reg + cz2_reg;
    assign bb_w = bb2_reg + cz2_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            h3_reg[0] <= gn3_pkg::PERM_ROM[aa_w][3:0];
            h3_reg[1] <= gn3_pkg::PERM_ROM[ba_w][3:0];
            h3_reg[2] <= gn3_pkg::PERM_ROM[ab_w][3:0];
            h3_reg[3] <= gn3_pkg::PERM_ROM[bb_w][3:0];
            h3_reg[4] <= gn3_pkg::PERM_ROM[8'(aa_w + 8'd1)][3:0];
            h3_reg[5] <= gn3_pkg::PERM_ROM[8'(ba_w + 8'd1)][3:0];
            h3_reg[6] <= gn3_pkg::PERM_ROM[8'(ab_w + 8'd1)][3:0];
            h3_reg[7] <= gn3_pkg::PERM_ROM[8'(bb_w + 8'd1)][3:0];
            for (int k = 0; k < 3; k++)
            begin
                fr3_reg[k] <= fr2_reg[k];
                // t3 = (t2 * t) >> F
                t3p_reg[k] <= tt2_reg[k][2*F-1:F] * fr2_reg[k];
                // p = (6 t^2 >> F) + 10 one - 15 t, always positive
                p3_reg[k]  <= PW'((({2'b0, tt2_reg[k], 1'b0} + {1'b0, tt2_reg[k], 2'b0})
                              >> F)) + PW'(10 * (2**F))
                              - PW'(({4'b0, fr2_reg[k]} << 4) - {4'b0, fr2_reg[k]});
            end
        end
    end

    // ---------------- stage 4: gradients; fade product
    gn3_pkg::val_t  g4_reg [8];
    logic [F+PW-1:0] fp4_reg [3];
    gn3_pkg::off_t  ox_w [2], oy_w [2], oz_w [2];

    assign ox_w[0] = gn3_pkg::off_t'({1'b0, fr3_reg[0]});
    assign ox_w[1] = ox_w[0] - gn3_pkg::off_t'(ONE);
    assign oy_w[0] = gn3_pkg::off_t'({1'b0, fr3_reg[1]});
    assign oy_w[1] = oy_w[0] - gn3_pkg::off_t'(ONE);
    assign oz_w[0] = gn3_pkg::off_t'({1'b0, fr3_reg[2]});
    assign oz_w[1] = oz_w[0] - gn3_pkg::off_t'(ONE);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // corner index i: bit0 = x side, bit1 = y side, bit2 = z side
            for (int i = 0; i < 8; i++)
            begin
                g4_reg[i] <= gn3_pkg::grad(h3_reg[i], ox_w[i%2], oy_w[(i/2)%2],
                                           oz_w[i/4]);
            end
            for (int k = 0; k < 3; k++)
            begin
                fp4_reg[k] <= t3p_reg[k][2*F-1:F] * p3_reg[k];
            end
        end
    end

    // fade result with clamp to one
    gn3_pkg::weight_t w_w [3];
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            if ((fp4_reg[k] >> F) > (F+PW)'(ONE))
                w_w[k] = ONE;
            else
                w_w[k] = gn3_pkg::weight_t'(fp4_reg[k] >> F);
        end
    end

    // ---------------- stage 5: x lerp products
    localparam int DW = gn3_pkg::VAL_W + 1;
    localparam int MW = DW + gn3_pkg::WT_W + 1;
    gn3_pkg::val_t        a5_reg [4];
    logic signed [MW-1:0] m5_reg [4];
    gn3_pkg::weight_t     w5_reg [2];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < 4; j++)
            begin
                a5_reg[j] <= g4_reg[2*j];
                m5_reg[j] <= MW'($signed({1'b0, w_w[0]}))
                             * (MW'(g4_reg[2*j+1]) - MW'(g4_reg[2*j]));
            end
            w5_reg[0] <= w_w[1];
            w5_reg[1] <= w_w[2];
        end
    end

    logic signed [DW-1:0] x_w [4];
    always_comb
    begin
        for (int j = 0; j < 4; j++)
            x_w[j] = DW'(a5_reg[j]) + DW'(m5_reg[j] >>> F);
    end

    // ---------------- stage 6: y lerp products
    logic signed [DW-1:0] a6_reg [2];
    logic signed [MW-1:0] m6_reg [2];
    gn3_pkg::weight_t     w6_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < 2; j++)
            begin
                a6_reg[j] <= x_w[2*j];
                m6_reg[j] <= MW'($signed({1'b0, w5_reg[0]}))
                             * (MW'(x_w[2*j+1]) - MW'(x_w[2*j]));
            end
            w6_reg <= w5_reg[1];
        end
    end

    logic signed [DW-1:0] y_w [2];
    assign y_w[0] = a6_reg[0] + DW'(m6_reg[0] >>> F);
    assign y_w[1] = a6_reg[1] + DW'(m6_reg[1] >>> F);

    // ---------------- stage 7: z lerp product
    logic signed [DW-1:0] a7_reg;
    logic signed [MW-1:0] m7_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a7_reg <= y_w[0];
            m7_reg <= MW'($signed({1'b0, w6_reg})) * (MW'(y_w[1]) - MW'(y_w[0]));
        end
    end

    // ---------------- stage 8: final sum
    logic signed [DW-1:0] r8_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r8_reg <= a7_reg + DW'(m7_reg >>> F);
        end
    end

    // ---------------- stage 9: scale to Q2.16 and saturate
    localparam int SW = DW + 17;
    logic signed [SW-1:0] s_w;
    logic signed [gn3_pkg::NOISE_W-1:0] out_reg;
    localparam logic signed [SW-1:0] SAT_HI = SW'(131071);
    localparam logic signed [SW-1:0] SAT_LO = -SW'(131072);

    always_comb
    begin
        if (F > 16)
            s_w = SW'(r8_reg) >>> (F - 16);
        else
            s_w = SW'(r8_reg) <<< (16 - F);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (s_w > SAT_HI)
                out_reg <= gn3_pkg::NOISE_W'(SAT_HI);
            else if (s_w < SAT_LO)
                out_reg <= gn3_pkg::NOISE_W'(SAT_LO);
            else
                out_reg <= gn3_pkg::NOISE_W'(s_w);
        end
    end

    assign out_ch.noise_value = out_reg;

    // ---------------- assertions
    // stalled output keeps its valid bit
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid)
        else $error("output valid dropped under stall");
    // accepted input shows up in first stage
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready |=> vld_reg[0])
        else $error("accepted transaction lost");
    // fade weights of a valid item never exceed one
    a_wt: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[3] |-> (w_w[0] <= ONE && w_w[1] <= ONE && w_w[2] <= ONE))
        else $error("fade weight out of range");
    // pipeline frozen while stalled
    a_frz: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("pipeline moved during stall");

endmodule
